// ----- sv/assert_macros.svh -----
// Assertion macros shared by the checker RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, masked during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, masked during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bcfc_pkg.sv -----
// Package for the block CRC-32 frame checker: request types, codes, constants, CRC step.
// No dependencies.
package bcfc_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int LEN_W           = 24;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_INFO_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_LEN = 2'd1;

    localparam logic [LEN_W-1:0] INFO_LEN_RST = 24'd4096;
    localparam logic [LEN_W-1:0] DATA_LEN_RST = 24'd4194304;

    localparam logic [1:0] STATUS_MATCH    = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_SHORT    = 2'd2;

    localparam logic KIND_INFO = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_image;
    } in_item_t;

    typedef struct packed {
        logic             block_kind;
        logic [LEN_W-1:0] block_bytes;
        logic [31:0]      computed_crc;
        logic [31:0]      stored_crc;
        logic [1:0]       check_status;
        logic             final_block;
    } out_item_t;

    // Reflected CRC-32, one byte.
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- sv/bcfc_tracker.sv -----
// Per-block state: CRC register, four-byte delay line, byte counter and block phase.
// Depends on bcfc_pkg. Works out the result of the offered request combinationally.
module bcfc_tracker #(
    parameter int LENGTH_BITS = bcfc_pkg::LENGTH_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       take,
    input  bcfc_pkg::in_item_t         item,
    input  logic [bcfc_pkg::LEN_W-1:0] info_len,
    input  logic [bcfc_pkg::LEN_W-1:0] data_len,
    output logic                       close,
    output bcfc_pkg::out_item_t        result
);

    localparam logic [LENGTH_BITS-1:0] CNT_MAX = '1;

    logic [31:0]            crc_reg, crc_next;
    logic [31:0]            tail_reg, tail_next;
    logic [2:0]             fill_reg, fill_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic                   phase_reg;

    logic [32:0] cnt_ext;
    logic [32:0] target_raw;
    logic [32:0] target_sat;
    logic [32:0] max_ext;
    logic [31:0] comp_crc;
    logic        is_short;

    always_comb
    begin
        crc_next   = fill_reg[2] ? bcfc_pkg::crc_byte(crc_reg, tail_reg[7:0]) : crc_reg;
        fill_next  = fill_reg[2] ? fill_reg : fill_reg + 3'd1;
        tail_next  = {item.data_byte, tail_reg[31:8]};
        count_next = (count_reg != CNT_MAX) ? count_reg + LENGTH_BITS'(1) : count_reg;

        cnt_ext    = 33'(count_next);
        max_ext    = 33'(CNT_MAX);
        target_raw = 33'(phase_reg ? data_len : info_len) + 33'd4;
        target_sat = (target_raw > max_ext) ? max_ext : target_raw;
        close      = item.end_of_image || (cnt_ext >= target_sat);

        comp_crc = crc_next ^ bcfc_pkg::CRC_ONES;
        is_short = cnt_ext < 33'd5;

        result.block_kind  = phase_reg;
        result.block_bytes = cnt_ext[bcfc_pkg::LEN_W-1:0];
        result.final_block = item.end_of_image;
        if (is_short)
        begin
            result.computed_crc = 32'd0;
            result.stored_crc   = 32'd0;
            result.check_status = bcfc_pkg::STATUS_SHORT;
        end
        else
        begin
            result.computed_crc = comp_crc;
            result.stored_crc   = tail_next;
            result.check_status = (comp_crc == tail_next) ? bcfc_pkg::STATUS_MATCH
                                                          : bcfc_pkg::STATUS_MISMATCH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= bcfc_pkg::CRC_ONES;
            tail_reg  <= 32'd0;
            fill_reg  <= 3'd0;
            count_reg <= '0;
            phase_reg <= bcfc_pkg::KIND_INFO;
        end
        else if (take)
        begin
            if (close)
            begin
                crc_reg   <= bcfc_pkg::CRC_ONES;
                tail_reg  <= 32'd0;
                fill_reg  <= 3'd0;
                count_reg <= '0;
                phase_reg <= item.end_of_image ? bcfc_pkg::KIND_INFO : bcfc_pkg::KIND_DATA;
            end
            else
            begin
                crc_reg   <= crc_next;
                tail_reg  <= tail_next;
                fill_reg  <= fill_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

// ----- sv/block_crc32_frame_checker_unit.sv -----
// Block CRC-32 frame checker, top level: config registers, result register, handshake.
// Depends on bcfc_pkg, bcfc_tracker and assert_macros.svh.
//
// Usage:
//   in_valid/in_stall/in_data carry the image, one byte per request, with
//   end_of_image on the last byte. out_valid/out_stall/out_data carry one
//   report per closed block (kind, length, computed and stored CRC, status).
//   cfg_write/cfg_index/cfg_data set the info and data payload lengths; write
//   only while the block is idle.
//   A block's report is registered and appears in the cycle after its last
//   byte is accepted. Throughput: one byte per cycle while in_stall is low;
//   the byte CRC update, counter compare and delay line sit combinationally
//   ahead of the result register. in_stall is raised only while a report is
//   held and out_stall is high; while the receiver stalls the held report
//   does not change and no byte is taken. Reset clears the CRC, delay line,
//   counter and phase (next byte starts an info block), drops any held
//   report and restores the lengths to 4096 and 4194304. end_of_image
//   returns the block to that same starting point after its report.
module block_crc32_frame_checker_unit #(
    parameter int LENGTH_BITS = bcfc_pkg::LENGTH_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  bcfc_pkg::in_item_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output bcfc_pkg::out_item_t            out_data,
    input  logic                           cfg_write,
    input  logic [bcfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcfc_pkg::LEN_W-1:0]     cfg_data
);

`include "assert_macros.svh"

    logic [bcfc_pkg::LEN_W-1:0] info_len_reg;
    logic [bcfc_pkg::LEN_W-1:0] data_len_reg;
    logic                       out_valid_reg, out_valid_next;
    bcfc_pkg::out_item_t        out_data_reg;
    bcfc_pkg::out_item_t        result;
    logic                       close;
    logic                       take;

    assign in_stall = out_valid_reg & out_stall;
    assign take     = in_valid & ~in_stall;

    bcfc_tracker #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (in_data),
        .info_len (info_len_reg),
        .data_len (data_len_reg),
        .close    (close),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_len_reg <= bcfc_pkg::INFO_LEN_RST;
            data_len_reg <= bcfc_pkg::DATA_LEN_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == bcfc_pkg::CFG_INFO_LEN)
            begin
                info_len_reg <= cfg_data;
            end
            else if (cfg_index == bcfc_pkg::CFG_DATA_LEN)
            begin
                data_len_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (take && close)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && close)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_NEXT(a_report_drains, out_valid && !out_stall && !take, !out_valid, "report not retired after delivery")
    `ASSERT_NOW(a_short_zero, out_valid && out_data.check_status == bcfc_pkg::STATUS_SHORT, out_data.computed_crc == 32'd0 && out_data.stored_crc == 32'd0, "short block carries CRC data")
    `ASSERT_NOW(a_status_crc, out_valid && out_data.check_status != bcfc_pkg::STATUS_SHORT, (out_data.check_status == bcfc_pkg::STATUS_MATCH) == (out_data.computed_crc == out_data.stored_crc), "status disagrees with CRC compare")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for block_crc32_frame_checker_unit: byte-stream driver, report monitor and a
// block CRC predictor. Depends on bcfc_pkg and the checker RTL only.
module testbench;

    localparam int CNT_MAX      = (1 << bcfc_pkg::LENGTH_BITS_DEF) - 1;
    localparam int RANDOM_REQS  = 1600;
    localparam int PHASE_REQS   = 150;
    localparam int SETTLE_CYC   = 4;
    localparam logic [bcfc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [bcfc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    bcfc_pkg::in_item_t             in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    bcfc_pkg::out_item_t            out_data;
    logic                           cfg_write = 1'b0;
    logic [bcfc_pkg::CFG_IDX_W-1:0] cfg_index = bcfc_pkg::CFG_INFO_LEN;
    logic [bcfc_pkg::LEN_W-1:0]     cfg_data  = '0;

    bcfc_pkg::in_item_t  image_q[$];
    bcfc_pkg::out_item_t report_q[$];

    // predictor state
    logic [31:0]                crc_acc    = bcfc_pkg::CRC_ONES;
    logic [31:0]                tail_word  = '0;
    int                         tail_cnt   = 0;
    int                         blk_len    = 0;
    bit                         data_phase = 1'b0;
    logic [bcfc_pkg::LEN_W-1:0] info_len   = bcfc_pkg::INFO_LEN_RST;
    logic [bcfc_pkg::LEN_W-1:0] data_len   = bcfc_pkg::DATA_LEN_RST;

    int fault_count     = 0;
    int requests_queued = 0;
    int requests_taken  = 0;
    int idle_pct        = 17;
    int stall_pct       = 17;

    block_crc32_frame_checker_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(2_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    function automatic logic [31:0] crc32_shift(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ b[i])
                r = (r >> 1) ^ bcfc_pkg::CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    task automatic restart_block();
        crc_acc   = bcfc_pkg::CRC_ONES;
        tail_word = '0;
        tail_cnt  = 0;
        blk_len   = 0;
    endtask

    task automatic track_byte(input bcfc_pkg::in_item_t req);
        bcfc_pkg::out_item_t rep;
        int                  limit;
        if (tail_cnt >= 4)
            crc_acc = crc32_shift(crc_acc, tail_word[7:0]);
        else
            tail_cnt++;
        tail_word = {req.data_byte, tail_word[31:8]};
        if (blk_len < CNT_MAX)
            blk_len++;
        limit = (data_phase ? int'(data_len) : int'(info_len)) + 4;
        if (limit > CNT_MAX)
            limit = CNT_MAX;
        if (req.end_of_image || blk_len >= limit)
        begin
            rep.block_kind  = data_phase ? bcfc_pkg::KIND_DATA : bcfc_pkg::KIND_INFO;
            rep.block_bytes = blk_len[bcfc_pkg::LEN_W-1:0];
            rep.final_block = req.end_of_image;
            if (blk_len < 5)
            begin
                rep.computed_crc = '0;
                rep.stored_crc   = '0;
                rep.check_status = bcfc_pkg::STATUS_SHORT;
            end
            else
            begin
                rep.computed_crc = ~crc_acc;
                rep.stored_crc   = tail_word;
                rep.check_status = (~crc_acc == tail_word) ? bcfc_pkg::STATUS_MATCH
                                                           : bcfc_pkg::STATUS_MISMATCH;
            end
            report_q.push_back(rep);
            restart_block();
            data_phase = !req.end_of_image;
        end
    endtask

    task automatic note_fault(input string what, input bcfc_pkg::out_item_t want,
                              input bcfc_pkg::out_item_t got);
        fault_count++;
        if (fault_count <= 10)
        begin
            $display("%s: expected kind %0d bytes %0d crc %h stored %h status %0d final %0d",
                     what, want.block_kind, want.block_bytes, want.computed_crc,
                     want.stored_crc, want.check_status, want.final_block);
            $display("    got kind %0d bytes %0d crc %h stored %h status %0d final %0d",
                     got.block_kind, got.block_bytes, got.computed_crc,
                     got.stored_crc, got.check_status, got.final_block);
        end
    endtask

    task automatic check_report(input bcfc_pkg::out_item_t got);
        bcfc_pkg::out_item_t want;
        if (report_q.size() == 0)
        begin
            note_fault("unexpected report", '0, got);
        end
        else
        begin
            want = report_q.pop_front();
            if (got.block_kind !== want.block_kind || got.block_bytes !== want.block_bytes
                || got.computed_crc !== want.computed_crc
                || got.stored_crc !== want.stored_crc
                || got.check_status !== want.check_status
                || got.final_block !== want.final_block)
                note_fault("report mismatch", want, got);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (image_q.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                in_data  <= image_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // monitor: register writes, accepted requests, accepted reports
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_block();
            data_phase = 1'b0;
            info_len   = bcfc_pkg::INFO_LEN_RST;
            data_len   = bcfc_pkg::DATA_LEN_RST;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == bcfc_pkg::CFG_INFO_LEN)
                    info_len = cfg_data;
                else if (cfg_index == bcfc_pkg::CFG_DATA_LEN)
                    data_len = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                track_byte(in_data);
                requests_taken++;
            end
            if (out_valid && !out_stall)
                check_report(out_data);
        end
    end

    task automatic push_req(input logic [7:0] b, input bit eoi);
        bcfc_pkg::in_item_t r;
        r.data_byte    = b;
        r.end_of_image = eoi;
        image_q.push_back(r);
        requests_queued++;
    endtask

    // payload of plen random bytes, trailing CRC little-endian, optional single-bit error
    task automatic push_block(input int plen, input bit corrupt, input bit last);
        logic [7:0]  blk[$];
        logic [31:0] acc;
        int          pick;
        acc = bcfc_pkg::CRC_ONES;
        for (int i = 0; i < plen; i++)
        begin
            blk.push_back(8'($urandom()));
            acc = crc32_shift(acc, blk[i]);
        end
        acc = ~acc;
        for (int i = 0; i < 4; i++)
            blk.push_back(acc[8*i +: 8]);
        if (corrupt)
        begin
            pick = $urandom_range(blk.size() - 1);
            blk[pick] = blk[pick] ^ 8'(1 << $urandom_range(7));
        end
        for (int i = 0; i < blk.size(); i++)
            push_req(blk[i], last && (i == blk.size() - 1));
    endtask

    task automatic push_random_image();
        int  nblk;
        int  plen;
        int  n;
        bit  last;
        if ($urandom_range(6) == 0)
        begin
            n = $urandom_range(1, 20);
            last = ($urandom_range(3) != 0);
            for (int i = 0; i < n; i++)
                push_req(8'($urandom()), last && (i == n - 1));
        end
        else
        begin
            nblk = $urandom_range(1, 4);
            for (int k = 0; k < nblk; k++)
            begin
                plen = (k == 0) ? int'(info_len) : int'(data_len);
                last = (k == nblk - 1);
                if (plen > 48)
                begin
                    last = 1'b1;
                    plen = $urandom_range(0, 40);
                end
                else if (last && $urandom_range(2) == 0)
                begin
                    plen = $urandom_range(0, plen);
                end
                push_block(plen, $urandom_range(7) == 0, last);
                if (last)
                    break;
            end
        end
    endtask

    task automatic write_reg(input logic [bcfc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bcfc_pkg::LEN_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (requests_taken != requests_queued || report_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    initial
    begin
        int                         phase;
        int                         phase_end;
        logic [bcfc_pkg::LEN_W-1:0] new_info;
        logic [bcfc_pkg::LEN_W-1:0] new_data;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset lengths: image closes on end_of_image well before the info length
        push_req(8'h00, 1'b0);
        push_req(8'hFF, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'hFF, 1'b0);
        push_req(8'h00, 1'b0);
        push_req(8'hFF, 1'b1);
        wait_drained();

        write_reg(bcfc_pkg::CFG_INFO_LEN, 24'd1);
        write_reg(bcfc_pkg::CFG_DATA_LEN, 24'd2);
        write_reg(CFG_UNUSED_A, 24'd0);
        push_block(1, 1'b0, 1'b0);
        push_block(2, 1'b1, 1'b0);
        push_block(2, 1'b0, 1'b1);
        wait_drained();

        // zero payload length: every block is at most four bytes and flagged short
        write_reg(bcfc_pkg::CFG_INFO_LEN, 24'd0);
        write_reg(bcfc_pkg::CFG_DATA_LEN, 24'd0);
        write_reg(CFG_UNUSED_B, 24'hFFFFFF);
        push_block(0, 1'b0, 1'b0);
        push_req(8'h5A, 1'b0);
        push_req(8'hA5, 1'b1);
        wait_drained();

        phase = 0;
        phase_end = requests_queued;
        while (requests_queued < phase_end + RANDOM_REQS)
        begin
            case (phase % 6)
                1:
                begin
                    new_info = 24'hFFFFFF;
                    new_data = 24'd1;
                end
                3:
                begin
                    new_info = 24'd1;
                    new_data = 24'hFFFFFF;
                end
                5:
                begin
                    new_info = 24'($urandom());
                    new_data = 24'($urandom());
                end
                default:
                begin
                    new_info = 24'($urandom_range(0, ($urandom_range(3) == 0) ? 40 : 10));
                    new_data = 24'($urandom_range(0, ($urandom_range(3) == 0) ? 40 : 10));
                end
            endcase
            idle_pct  = (phase % 6 == 2) ? 0 : 17;
            stall_pct = idle_pct;
            write_reg(bcfc_pkg::CFG_INFO_LEN, new_info);
            write_reg(bcfc_pkg::CFG_DATA_LEN, new_data);
            if ($urandom_range(2) == 0)
                write_reg($urandom_range(1) ? CFG_UNUSED_A : CFG_UNUSED_B, 24'($urandom()));
            while (image_q.size() < PHASE_REQS)
                push_random_image();
            // sender holds off until every report is back
            wait_drained();
            phase++;
        end

        wait_drained();
        if (fault_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
